>>> src/dfr_pkg.sv
// Shared types and constants for the DLE framed record receiver.
`timescale 1ns / 1ps
package dfr_pkg;

  localparam logic [7:0] DLE = 8'h10;
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;
  localparam logic [7:0] ACK = 8'h06;
  localparam logic [7:0] NAK = 8'h15;

  // ETX replaces the DLE already summed while in the escape state
  localparam logic [7:0] ESC_ETX_ADJ = ETX - DLE;

  localparam logic [7:0] MAX_LEN_RST = 8'd255;

  typedef enum logic [2:0] {
    PH_HUNT_DLE = 3'd0,
    PH_HUNT_STX = 3'd1,
    PH_DATA     = 3'd2,
    PH_ESC      = 3'd3,
    PH_END_DLE  = 3'd4,
    PH_END_ETX  = 3'd5,
    PH_CHECK    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_ACCEPT  = 3'd1,
    EV_BAD_SUM = 3'd2,
    EV_ABORT   = 3'd3,
    EV_RESTART = 3'd4
  } event_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [7:0] index;
    logic [7:0] length;
    logic       reply_valid;
    logic [7:0] reply_byte;
  } res_t;

endpackage

>>> src/dfr_ifs.sv
// Channel interfaces: received bytes, result records, max_len writes.
`timescale 1ns / 1ps
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] index;
  logic [7:0] length;
  logic       reply_valid;
  logic [7:0] reply_byte;

  modport source (output valid, output event_res, output data_byte, output index,
                  output length, output reply_valid, output reply_byte, input ready);
  modport sink   (input valid, input event_res, input data_byte, input index,
                  input length, input reply_valid, input reply_byte, output ready);
  modport mon    (input valid, input event_res, input data_byte, input index,
                  input length, input reply_valid, input reply_byte, input ready);
endinterface

interface dfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_len;

  modport source (output valid, output max_len, input ready);
  modport sink   (input valid, input max_len, output ready);
endinterface

>>> src/dfr_core.sv
// Deframing state machine: phase, checksum and byte counters.
`timescale 1ns / 1ps
module dfr_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,      // byte in b is consumed this cycle
  input  logic [7:0]    b,
  input  logic [7:0]    max_len,
  output logic          has_res,
  output dfr_pkg::res_t res
);

  dfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] csum_r, csum_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] stored_r, stored_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= dfr_pkg::PH_HUNT_DLE;
      csum_r   <= '0;
      remain_r <= '0;
      stored_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      csum_r   <= csum_nxt;
      remain_r <= remain_nxt;
      stored_r <= stored_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    csum_nxt   = csum_r;
    remain_nxt = remain_r;
    stored_nxt = stored_r;
    has_res    = 1'b0;
    res        = '0;
    unique case (phase_r)
      dfr_pkg::PH_HUNT_DLE: begin
        if (b == dfr_pkg::DLE) phase_nxt = dfr_pkg::PH_HUNT_STX;
      end
      dfr_pkg::PH_HUNT_STX: begin
        if (b == dfr_pkg::STX) begin
          csum_nxt   = dfr_pkg::STX;
          remain_nxt = max_len;
          stored_nxt = '0;
          phase_nxt  = (max_len == 8'd0) ? dfr_pkg::PH_END_DLE : dfr_pkg::PH_DATA;
        end else begin
          phase_nxt = dfr_pkg::PH_HUNT_DLE;
        end
      end
      dfr_pkg::PH_DATA, dfr_pkg::PH_ESC: begin
        if (phase_r == dfr_pkg::PH_DATA) csum_nxt = csum_r + b;
        if (phase_r == dfr_pkg::PH_DATA && b == dfr_pkg::DLE) begin
          phase_nxt = dfr_pkg::PH_ESC;
        end else if (phase_r == dfr_pkg::PH_DATA || b == dfr_pkg::DLE) begin
          // payload byte (an escaped DLE was summed on its first copy)
          stored_nxt    = stored_r + 8'd1;
          remain_nxt    = remain_r - 8'd1;
          phase_nxt     = (remain_r == 8'd1) ? dfr_pkg::PH_END_DLE : dfr_pkg::PH_DATA;
          has_res       = 1'b1;
          res.event_res = dfr_pkg::EV_DATA;
          res.data_byte = b;
          res.index     = stored_r;
        end else if (b == dfr_pkg::ETX) begin
          csum_nxt  = csum_r + dfr_pkg::ESC_ETX_ADJ;
          phase_nxt = dfr_pkg::PH_CHECK;
        end else if (b == dfr_pkg::STX) begin
          has_res       = 1'b1;
          res.event_res = dfr_pkg::EV_RESTART;
          res.length    = stored_r;
          csum_nxt      = dfr_pkg::STX;
          remain_nxt    = max_len;
          stored_nxt    = '0;
          phase_nxt     = (max_len == 8'd0) ? dfr_pkg::PH_END_DLE : dfr_pkg::PH_DATA;
        end else begin
          has_res       = 1'b1;
          res.event_res = dfr_pkg::EV_ABORT;
          res.length    = stored_r;
          phase_nxt     = dfr_pkg::PH_HUNT_DLE;
        end
      end
      dfr_pkg::PH_END_DLE: begin
        if (b == dfr_pkg::DLE) begin
          phase_nxt = dfr_pkg::PH_END_ETX;
        end else begin
          has_res       = 1'b1;
          res.event_res = dfr_pkg::EV_ABORT;
          res.length    = stored_r;
          phase_nxt     = dfr_pkg::PH_HUNT_DLE;
        end
      end
      dfr_pkg::PH_END_ETX: begin
        if (b == dfr_pkg::ETX) begin
          csum_nxt  = csum_r + dfr_pkg::ETX;
          phase_nxt = dfr_pkg::PH_CHECK;
        end else begin
          has_res       = 1'b1;
          res.event_res = dfr_pkg::EV_ABORT;
          res.length    = stored_r;
          phase_nxt     = dfr_pkg::PH_HUNT_DLE;
        end
      end
      dfr_pkg::PH_CHECK: begin
        phase_nxt       = dfr_pkg::PH_HUNT_DLE;
        has_res         = 1'b1;
        res.length      = stored_r;
        res.reply_valid = 1'b1;
        if (b == csum_r) begin
          res.event_res  = dfr_pkg::EV_ACCEPT;
          res.reply_byte = dfr_pkg::ACK;
        end else begin
          res.event_res  = dfr_pkg::EV_BAD_SUM;
          res.reply_byte = dfr_pkg::NAK;
        end
      end
      default: begin
        phase_nxt = dfr_pkg::PH_HUNT_DLE;
      end
    endcase
  end

endmodule

>>> src/dle_framed_record_receiver.sv
// Top level of the DLE STX ... DLE ETX LRC record receiver.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : one received serial byte per request (rx_byte).
//   out_ch : one result request per payload byte, frame end, restart or
//            abort: event_res, data_byte, index, length, reply_valid and
//            reply_byte (ACK or NAK to transmit back to the sender).
//   cfg_ch : writes max_len; always ready. Write only while idle. The new
//            value is picked up at the next frame start or restart.
// Timing:
//   A byte accepted on in_ch is held in the input register and runs
//   through the deframer from there; its result is captured in the
//   output register and offered on out_ch from that register.
//   Throughput is one byte per cycle while out_ch is not stalled; the
//   phase/checksum update in dfr_core is the only loop.
//   Bytes that give no result (hunting, DLE, ETX) retire without touching
//   the output register.
// Reset: synchronous, active low; phase goes back to hunting for DLE,
//   max_len returns to 255, both pipeline registers are emptied.
// Stall: while out_ch.ready is low the held result stays put; a byte that
//   needs the output waits in the input register and in_ch.ready drops.
module dle_framed_record_receiver (
  input logic      clk,
  input logic      rst_n,
  dfr_in_if.sink   in_ch,
  dfr_out_if.source out_ch,
  dfr_cfg_if.sink  cfg_ch
);

  logic [7:0]    max_len_r;
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          out_valid_r;
  dfr_pkg::res_t out_res_r;

  logic          has_res;
  dfr_pkg::res_t res;
  logic          out_free;
  logic          s1_fire;
  logic          in_fire;

  // config register, always accepts
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= dfr_pkg::MAX_LEN_RST;
    end else if (cfg_ch.valid) begin
      max_len_r <= cfg_ch.max_len;
    end
  end

  // stage 1 retires when it needs no output slot or one is free
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!has_res || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_ch.rx_byte;
  end

  dfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_fire),
    .b       (s1_byte_r),
    .max_len (max_len_r),
    .has_res (has_res),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_res) out_res_r <= res;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = out_res_r.event_res;
  assign out_ch.data_byte   = out_res_r.data_byte;
  assign out_ch.index       = out_res_r.index;
  assign out_ch.length      = out_res_r.length;
  assign out_ch.reply_valid = out_res_r.reply_valid;
  assign out_ch.reply_byte  = out_res_r.reply_byte;

endmodule

>>> src/dfr_checker.sv
// Port-level assertions for the record receiver, bound to the top level.
`timescale 1ns / 1ps
module dfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_res,
  input logic       out_reply_valid,
  input logic [7:0] out_reply_byte
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing offered right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a reply goes out exactly on frame end
  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reply_valid ==
      (out_event_res == dfr_pkg::EV_ACCEPT || out_event_res == dfr_pkg::EV_BAD_SUM)))
    else $error("reply_valid does not match event");

  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == dfr_pkg::EV_ACCEPT |->
      out_reply_byte == dfr_pkg::ACK)
    else $error("accept without ACK");

  // no result can be produced by a byte accepted in the previous cycle only
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(out_valid, 1) ||
      $past(!in_ready, 1))
    else $error("result without a preceding request");

endmodule

bind dle_framed_record_receiver dfr_checker u_dfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_event_res   (out_ch.event_res),
  .out_reply_valid (out_ch.reply_valid),
  .out_reply_byte  (out_ch.reply_byte)
);

>>> sim/tb_dle_framed_record_receiver.sv
// Testbench for dle_framed_record_receiver: byte stream in, predicted records checked.
`timescale 1ns / 1ps
module tb_dle_framed_record_receiver;

  // Bytes pushed per random phase; ten phases plus the full-length frame
  // give roughly the target stream.
  localparam int unsigned PHASE_BYTES = 30;
  // Result path is two registers deep; the idle wait settles beyond that.
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_LONG_STALL
  } rdy_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side copies of everything driven into the block, known from time 0.
  logic       in_vld = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_rdy = 1'b0;
  logic       cfg_vld = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  dfr_in_if  in_ch ();
  dfr_out_if out_ch ();
  dfr_cfg_if cfg_ch ();

  assign in_ch.valid    = in_vld;
  assign in_ch.rx_byte  = in_byte;
  assign out_ch.ready   = out_rdy;
  assign cfg_ch.valid   = cfg_vld;
  assign cfg_ch.max_len = cfg_data;

  dle_framed_record_receiver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Serial bytes waiting for the driver, and records the deframer must produce.
  logic [7:0]    rx_stream_q [$];
  dfr_pkg::res_t deframed_q [$];

  // Deframer state, mirrors the block after reset.
  dfr_pkg::phase_t frame_phase  = dfr_pkg::PH_HUNT_DLE;
  logic [7:0]      run_sum      = 8'h00;
  logic [7:0]      bytes_left   = 8'h00;
  logic [7:0]      bytes_stored = 8'h00;
  logic [7:0]      cur_max_len  = dfr_pkg::MAX_LEN_RST;

  int unsigned mismatch_cnt = 0;

  // Driver burst/gap bookkeeping.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver stall pattern.
  rdy_mode_t   rdy_mode  = RDY_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned rdy_cyc   = 0;

  //--------------------------------------------------------------------------
  // Deframer prediction
  //--------------------------------------------------------------------------

  function automatic dfr_pkg::res_t make_rec(dfr_pkg::event_t ev, logic [7:0] data,
                                             logic [7:0] idx, logic [7:0] len,
                                             logic rv, logic [7:0] rb);
    dfr_pkg::res_t r;
    r.event_res   = ev;
    r.data_byte   = data;
    r.index       = idx;
    r.length      = len;
    r.reply_valid = rv;
    r.reply_byte  = rb;
    return r;
  endfunction

  // Frame start or restart: sum seeded with STX, max_len latched here only.
  task automatic open_frame();
    run_sum      = dfr_pkg::STX;
    bytes_left   = cur_max_len;
    bytes_stored = 8'h00;
    frame_phase  = (bytes_left == 8'h00) ? dfr_pkg::PH_END_DLE : dfr_pkg::PH_DATA;
  endtask

  task automatic store_payload(logic [7:0] b);
    deframed_q.push_back(make_rec(dfr_pkg::EV_DATA, b, bytes_stored, 8'h00, 1'b0, 8'h00));
    bytes_stored = bytes_stored + 8'd1;
    bytes_left   = bytes_left - 8'd1;
    frame_phase  = (bytes_left == 8'h00) ? dfr_pkg::PH_END_DLE : dfr_pkg::PH_DATA;
  endtask

  task automatic drop_frame();
    frame_phase = dfr_pkg::PH_HUNT_DLE;
    deframed_q.push_back(make_rec(dfr_pkg::EV_ABORT, 8'h00, 8'h00, bytes_stored, 1'b0,
                                  8'h00));
  endtask

  task automatic deframe_byte(logic [7:0] b);
    logic [7:0] old_len;
    case (frame_phase)
      dfr_pkg::PH_HUNT_DLE: begin
        if (b == dfr_pkg::DLE) frame_phase = dfr_pkg::PH_HUNT_STX;
      end
      dfr_pkg::PH_HUNT_STX: begin
        if (b == dfr_pkg::STX) open_frame();
        else frame_phase = dfr_pkg::PH_HUNT_DLE;
      end
      dfr_pkg::PH_DATA: begin
        // DLE is summed here; if it turns out to be an escape it is not summed again
        run_sum = run_sum + b;
        if (b == dfr_pkg::DLE) frame_phase = dfr_pkg::PH_ESC;
        else store_payload(b);
      end
      dfr_pkg::PH_ESC: begin
        if (b == dfr_pkg::DLE) begin
          store_payload(b);
        end else if (b == dfr_pkg::ETX) begin
          // swap the DLE already summed for the ETX
          run_sum     = run_sum + dfr_pkg::ETX - dfr_pkg::DLE;
          frame_phase = dfr_pkg::PH_CHECK;
        end else if (b == dfr_pkg::STX) begin
          old_len = bytes_stored;
          open_frame();
          deframed_q.push_back(make_rec(dfr_pkg::EV_RESTART, 8'h00, 8'h00, old_len, 1'b0,
                                        8'h00));
        end else begin
          drop_frame();
        end
      end
      dfr_pkg::PH_END_DLE: begin
        if (b == dfr_pkg::DLE) frame_phase = dfr_pkg::PH_END_ETX;
        else drop_frame();
      end
      dfr_pkg::PH_END_ETX: begin
        // full frame: closing DLE not summed, ETX is
        if (b == dfr_pkg::ETX) begin
          run_sum     = run_sum + dfr_pkg::ETX;
          frame_phase = dfr_pkg::PH_CHECK;
        end else begin
          drop_frame();
        end
      end
      dfr_pkg::PH_CHECK: begin
        frame_phase = dfr_pkg::PH_HUNT_DLE;
        if (b == run_sum)
          deframed_q.push_back(make_rec(dfr_pkg::EV_ACCEPT, 8'h00, 8'h00, bytes_stored,
                                        1'b1, dfr_pkg::ACK));
        else
          deframed_q.push_back(make_rec(dfr_pkg::EV_BAD_SUM, 8'h00, 8'h00, bytes_stored,
                                        1'b1, dfr_pkg::NAK));
      end
      default: frame_phase = dfr_pkg::PH_HUNT_DLE;
    endcase
  endtask

  //--------------------------------------------------------------------------
  // Stream generation
  //--------------------------------------------------------------------------

  // Anything but DLE: safe filler that never opens or escapes.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == dfr_pkg::DLE) b = 8'h11;
    return b;
  endfunction

  // Random byte leaning on the control characters.
  function automatic logic [7:0] ctl_byte();
    case ($urandom_range(0, 9))
      0, 1: return dfr_pkg::DLE;
      2: return dfr_pkg::STX;
      3: return dfr_pkg::ETX;
      4: return ($urandom_range(0, 1) != 0) ? dfr_pkg::ACK : dfr_pkg::NAK;
      default: return 8'($urandom);
    endcase
  endfunction

  // Well-formed DLE STX payload DLE ETX LRC, payload DLEs doubled.
  task automatic send_frame(int unsigned n, bit good_lrc);
    logic [7:0]  sum;
    logic [7:0]  p;
    int unsigned i;
    sum = dfr_pkg::STX;
    rx_stream_q.push_back(dfr_pkg::DLE);
    rx_stream_q.push_back(dfr_pkg::STX);
    for (i = 0; i < n; i++) begin
      p = ($urandom_range(0, 4) == 0) ? dfr_pkg::DLE : 8'($urandom);
      sum = sum + p;
      rx_stream_q.push_back(p);
      if (p == dfr_pkg::DLE) rx_stream_q.push_back(dfr_pkg::DLE);
    end
    sum = sum + dfr_pkg::ETX;
    rx_stream_q.push_back(dfr_pkg::DLE);
    rx_stream_q.push_back(dfr_pkg::ETX);
    rx_stream_q.push_back(good_lrc ? sum : (sum ^ 8'($urandom_range(1, 255))));
  endtask

  // Mostly good frames; the rest restarts, bad escapes, overruns and line noise.
  task automatic fill_phase(int unsigned target);
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    int unsigned lim;
    start = rx_stream_q.size();
    lim   = cur_max_len;
    while (rx_stream_q.size() - start < target) begin
      repeat ($urandom_range(0, 2)) rx_stream_q.push_back(plain_byte());
      kind = $urandom_range(0, 99);
      n = (lim > 12) ? $urandom_range(0, 12) : $urandom_range(0, lim);
      if (lim <= 24 && $urandom_range(0, 3) == 0) n = lim;
      if (kind < 65) begin
        send_frame(n, $urandom_range(0, 4) != 0);
      end else if (kind < 75) begin
        // partial frame, then a fresh start inside it
        rx_stream_q.push_back(dfr_pkg::DLE);
        rx_stream_q.push_back(dfr_pkg::STX);
        repeat ($urandom_range(0, 3)) rx_stream_q.push_back(plain_byte());
        send_frame(n, 1'b1);
      end else if (kind < 85) begin
        rx_stream_q.push_back(dfr_pkg::DLE);
        rx_stream_q.push_back(dfr_pkg::STX);
        repeat ($urandom_range(0, 3)) rx_stream_q.push_back(plain_byte());
        rx_stream_q.push_back(dfr_pkg::DLE);
        rx_stream_q.push_back(ctl_byte());
      end else if (kind < 92) begin
        // run past max_len (when it is at most 20) without the closing DLE ETX
        rx_stream_q.push_back(dfr_pkg::DLE);
        rx_stream_q.push_back(dfr_pkg::STX);
        repeat ((lim <= 20) ? lim + 1 : $urandom_range(1, 6))
          rx_stream_q.push_back(plain_byte());
        rx_stream_q.push_back(ctl_byte());
      end else begin
        repeat ($urandom_range(1, 8)) rx_stream_q.push_back(ctl_byte());
      end
    end
  endtask

  //--------------------------------------------------------------------------
  // Phase control
  //--------------------------------------------------------------------------

  // Idle = nothing queued, nothing on the bus, every record seen, pipe drained.
  task automatic wait_idle();
    do @(negedge clk);
    while (rx_stream_q.size() != 0 || in_vld || deframed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_len(logic [7:0] val);
    @(posedge clk);
    cfg_vld  <= 1'b1;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_vld     <= 1'b0;
    cur_max_len = val;
  endtask

  initial begin
    logic [7:0] len_plan [9];
    int unsigned k;
    len_plan = '{8'd0, 8'd1, 8'd2, 8'd255, 8'd3, 8'd16, 8'd7, 8'd0, 8'd0};
    len_plan[8] = 8'($urandom_range(4, 40));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, max_len at reset value.
    // Hunt: noise, DLE DLE does not arm, lone STX ignored.
    rx_stream_q = {rx_stream_q, 8'h00, 8'hFF, dfr_pkg::DLE, dfr_pkg::DLE, dfr_pkg::STX};
    // Payload extremes, escaped DLE, restart, then accept (sum 02+55+03).
    rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, 8'h00, 8'hFF, dfr_pkg::DLE,
                   dfr_pkg::DLE, dfr_pkg::DLE, dfr_pkg::STX,
                   8'h55, dfr_pkg::DLE, dfr_pkg::ETX, 8'h5A};
    // Checksum mismatch, then bad escape abort.
    rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, 8'h01, dfr_pkg::DLE,
                   dfr_pkg::ETX, 8'h00};
    rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, 8'h07, dfr_pkg::DLE, 8'h41};
    fill_phase(PHASE_BYTES);

    for (k = 0; k < 9; k++) begin
      wait_idle();
      write_max_len(len_plan[k]);
      @(negedge clk);
      if (k == 0) begin
        // Empty frame accepted; missing DLE; DLE then STX after a full frame.
        rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, dfr_pkg::DLE,
                       dfr_pkg::ETX, 8'h05};
        rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, 8'h33};
        rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, dfr_pkg::DLE,
                       dfr_pkg::STX};
      end else if (k == 1) begin
        // Escaped DLE fills the frame; overrun aborts.
        rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, dfr_pkg::DLE,
                       dfr_pkg::DLE, dfr_pkg::DLE, dfr_pkg::ETX, 8'h15};
        rx_stream_q = {rx_stream_q, dfr_pkg::DLE, dfr_pkg::STX, 8'h20, 8'h21};
      end else if (len_plan[k] == 8'd255) begin
        // One frame at full length: last index 254, length 255.
        send_frame(255, 1'b1);
      end
      fill_phase(PHASE_BYTES);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("dle_framed_record_receiver test passed");
    end else begin
      $display("dle_framed_record_receiver test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("dle_framed_record_receiver test failed");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; valid held until accepted
  //--------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_vld <= 1'b0;
    end else begin
      if (in_vld && in_ch.ready) deframe_byte(in_byte);
      // bus free for a new request?
      if (!in_vld || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_vld <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          in_vld  <= 1'b1;
          in_byte <= rx_stream_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 19))
              0, 1, 2: gap_left = $urandom_range(4, 15);
              3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(1, 3);
              default: gap_left = 0;
            endcase
          end
        end else begin
          in_vld <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: stall pattern on ready, compare each record with the oldest
  //--------------------------------------------------------------------------

  task automatic report(string what, dfr_pkg::res_t want, dfr_pkg::res_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%s: exp ev=%0d data=%02h idx=%0d len=%0d rv=%0b rb=%02h",
               what, want.event_res, want.data_byte, want.index, want.length,
               want.reply_valid, want.reply_byte,
               " | got ev=%0d data=%02h idx=%0d len=%0d rv=%0b rb=%02h",
               got.event_res, got.data_byte, got.index, got.length,
               got.reply_valid, got.reply_byte);
  endtask

  task automatic check_record();
    dfr_pkg::res_t got;
    dfr_pkg::res_t want;
    got.event_res   = out_ch.event_res;
    got.data_byte   = out_ch.data_byte;
    got.index       = out_ch.index;
    got.length      = out_ch.length;
    got.reply_valid = out_ch.reply_valid;
    got.reply_byte  = out_ch.reply_byte;
    if (deframed_q.size() == 0) begin
      report("unexpected record", '0, got);
    end else begin
      want = deframed_q.pop_front();
      if (got !== want) report("record mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_rdy <= 1'b0;
    end else begin
      if (out_ch.valid && out_rdy) check_record();
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      rdy_cyc++;
      case (rdy_mode)
        RDY_ALWAYS:  out_rdy <= 1'b1;
        RDY_COIN:    out_rdy <= 1'($urandom_range(0, 1));
        RDY_SPARSE:  out_rdy <= (rdy_cyc % 4 == 0);
        default:     out_rdy <= (rdy_cyc % 20 < 6);
      endcase
    end
  end

endmodule
